// ----- design/ir_pulse_capture_assert.svh -----
// ----------------------------------------------------------------------------
// IR pulse capture assertion macros
// Shared assertion forms for the pulse capture checker.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_CAPTURE_ASSERT_SVH
`define IR_PULSE_CAPTURE_ASSERT_SVH

// same-cycle implication
`define IRPC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/irpc_pkg.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture package
// Operation and phase codes, and the command word passed from front to back.
// ----------------------------------------------------------------------------
package irpc_pkg;

   localparam logic [1:0] OP_EDGE     = 2'd0;
   localparam logic [1:0] OP_OVERFLOW = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_REARM    = 2'd3;

   localparam logic [2:0] PH_WAITING   = 3'd0;
   localparam logic [2:0] PH_MARK      = 3'd1;
   localparam logic [2:0] PH_SPACE     = 3'd2;
   localparam logic [2:0] PH_CAPTURING = 3'd3;
   localparam logic [2:0] PH_PENDING   = 3'd4;

   localparam logic [15:0] ACCUM_MAX     = 16'hFFFF;
   localparam logic [15:0] OVERFLOW_STEP = 16'd256;

   typedef enum logic [1:0] {
      CMD_EDGE,
      CMD_OVERFLOW,
      CMD_READ,
      CMD_REARM
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   timer_high;
      logic [6:0]   read_index;
      logic         read_in_range;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// ----- design/irpc_req_if.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture request channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface irpc_req_if;

   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] timer_high;
   logic [6:0] read_index;

   modport source (output valid, output operation, output timer_high,
                   output read_index, input ready);
   modport sink   (input valid, input operation, input timer_high,
                   input read_index, output ready);

endinterface

// ----- design/irpc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture response channel
// Valid/ready channel carrying one status word per event.
// ----------------------------------------------------------------------------
interface irpc_rsp_if;

   logic        valid;
   logic        ready;
   logic [2:0]  capture_phase;
   logic [15:0] leader_mark_ticks;
   logic [15:0] leader_space_ticks;
   logic [6:0]  stored_count;
   logic [7:0]  read_width;
   logic        next_edge_rising;

   modport source (output valid, output capture_phase, output leader_mark_ticks,
                   output leader_space_ticks, output stored_count,
                   output read_width, output next_edge_rising, input ready);
   modport sink   (input valid, input capture_phase, input leader_mark_ticks,
                   input leader_space_ticks, input stored_count,
                   input read_width, input next_edge_rising, output ready);

endinterface

// ----- design/irpc_ram.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture RAM
// Generic single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module irpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 127,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/irpc_front.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture front end
// Accepts event words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module irpc_front import irpc_pkg::*; #(
   parameter int EDGE_CAPACITY = 128
) (
   input  logic           clock,
   input  logic           reset,
   irpc_req_if.sink       req_bus,
   output queue_head_type head,
   input  logic           pop
);

   localparam int STORE_DEPTH = EDGE_CAPACITY - 1;
   localparam int CW          = $clog2(EDGE_CAPACITY);
   localparam int LW          = (CW > 7) ? CW : 7;

   cmd_type    cmd;
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   always_comb begin
      unique case (req_bus.operation)
         OP_EDGE:     cmd.kind = CMD_EDGE;
         OP_OVERFLOW: cmd.kind = CMD_OVERFLOW;
         OP_READ:     cmd.kind = CMD_READ;
         OP_REARM:    cmd.kind = CMD_REARM;
      endcase
      cmd.timer_high    = req_bus.timer_high;
      cmd.read_index    = req_bus.read_index;
      cmd.read_in_range = LW'(req_bus.read_index) < LW'(STORE_DEPTH);
   end

   assign req_bus.ready = (fill_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

// ----- design/irpc_exec.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture back end
// Runs the capture state machine, owns the edge memory, drives the response.
// ----------------------------------------------------------------------------
module irpc_exec import irpc_pkg::*; #(
   parameter int EDGE_CAPACITY = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   irpc_rsp_if.source     rsp_bus
);

   localparam int STORE_DEPTH = EDGE_CAPACITY - 1;
   localparam int CW          = $clog2(EDGE_CAPACITY);
   localparam int LW          = (CW > 7) ? CW : 7;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [2:0] {
      S_WAITING   = PH_WAITING,
      S_MARK      = PH_MARK,
      S_SPACE     = PH_SPACE,
      S_CAPTURING = PH_CAPTURING,
      S_PENDING   = PH_PENDING
   } state_type;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? ACCUM_MAX : s[15:0];
   endfunction

   state_type   phase_ff, phase_in;
   logic [15:0] mark_ff, mark_in;
   logic [15:0] space_ff, space_in;
   logic [CW-1:0] count_ff, count_in;
   logic        pol_ff, pol_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_rd_ff, out_rd_in;

   logic          go;
   logic          wr_en;
   logic          rd_en;
   logic [7:0]    rd_data;
   logic [LW-1:0] count_ext;
   logic [LW-1:0] index_ext;

   assign go  = head.valid && (!out_valid_ff || rsp_bus.ready);
   assign pop = go;

   always_comb begin
      phase_in  = phase_ff;
      mark_in   = mark_ff;
      space_in  = space_ff;
      count_in  = count_ff;
      pol_in    = pol_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      out_rd_in = out_rd_ff;
      if (go) begin
         out_rd_in = 1'b0;
         unique case (head.cmd.kind)
            CMD_EDGE: begin
               if (phase_ff != S_PENDING) begin
                  pol_in = ~pol_ff;
                  unique case (phase_ff)
                     S_WAITING: begin
                        mark_in  = '0;
                        space_in = '0;
                        count_in = '0;
                        phase_in = S_MARK;
                     end
                     S_MARK: begin
                        mark_in  = sat_add(mark_ff, {8'd0, head.cmd.timer_high});
                        phase_in = S_SPACE;
                     end
                     S_SPACE: begin
                        space_in = sat_add(space_ff, {8'd0, head.cmd.timer_high});
                        phase_in = S_CAPTURING;
                     end
                     S_CAPTURING: begin
                        if (count_ff < CW'(STORE_DEPTH)) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CMD_OVERFLOW: begin
               if (phase_ff == S_MARK) begin
                  mark_in = sat_add(mark_ff, OVERFLOW_STEP);
               end else if (phase_ff == S_SPACE) begin
                  space_in = sat_add(space_ff, OVERFLOW_STEP);
               end else begin
                  pol_in   = 1'b0;
                  phase_in = S_PENDING;
               end
            end
            CMD_READ: begin
               rd_en     = head.cmd.read_in_range;
               out_rd_in = head.cmd.read_in_range;
            end
            CMD_REARM: begin
               if (phase_ff == S_PENDING) begin
                  phase_in = S_WAITING;
               end
            end
         endcase
      end
      if (go) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= S_WAITING;
         mark_ff      <= '0;
         space_ff     <= '0;
         count_ff     <= '0;
         pol_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_rd_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mark_ff      <= mark_in;
         space_ff     <= space_in;
         count_ff     <= count_in;
         pol_ff       <= pol_in;
         out_valid_ff <= out_valid_in;
         out_rd_ff    <= out_rd_in;
      end
   end

   assign count_ext = LW'(count_ff);
   assign index_ext = LW'(head.cmd.read_index);

   irpc_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (head.cmd.timer_high),
      .rd_en   (rd_en),
      .rd_addr (index_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.capture_phase      = phase_ff;
   assign rsp_bus.leader_mark_ticks  = mark_ff;
   assign rsp_bus.leader_space_ticks = space_ff;
   assign rsp_bus.stored_count       = count_ext[6:0];
   assign rsp_bus.read_width         = out_rd_ff ? rd_data : 8'd0;
   assign rsp_bus.next_edge_rising   = pol_ff;

endmodule

// ----- design/ir_pulse_capture.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture
// Captures an infrared remote frame as leader durations and edge widths.
// ----------------------------------------------------------------------------
// Takes one event word per clock while the queue has room and returns one
// status word per event, in order. An accepted word enters a two-entry
// command queue and its status word is registered as it leaves the queue;
// with the response side ready the block sustains one event per cycle,
// bounded by the state update and the edge memory's one write and one read
// port. The edge memory holds EDGE_CAPACITY-1 widths and is not cleared
// between frames; reading an entry that was never written returns garbage.
module ir_pulse_capture import irpc_pkg::*; #(
   parameter int EDGE_CAPACITY = 128
) (
   input  logic         clock,
   input  logic         reset,
   irpc_req_if.sink     req_bus,
   irpc_rsp_if.source   rsp_bus
);

   queue_head_type head;
   logic           pop;

   irpc_front #(
      .EDGE_CAPACITY (EDGE_CAPACITY)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   irpc_exec #(
      .EDGE_CAPACITY (EDGE_CAPACITY)
   ) u_exec (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- design/irpc_checker.sv -----
// ----------------------------------------------------------------------------
// IR pulse capture checker
// Port-level checks on response ordering and frame bookkeeping.
// ----------------------------------------------------------------------------
`include "ir_pulse_capture_assert.svh"

module irpc_checker import irpc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_capture_phase,
   input logic [15:0] rsp_leader_mark_ticks,
   input logic [15:0] rsp_leader_space_ticks,
   input logic [6:0]  rsp_stored_count,
   input logic [7:0]  rsp_read_width,
   input logic        rsp_next_edge_rising
);

   logic        req_acc;
   logic        rsp_acc;
   logic [2:0]  outstanding_ff, outstanding_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [2:0]  prev_phase_ff, prev_phase_in;
   logic [15:0] prev_mark_ff, prev_mark_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      case ({req_acc, rsp_acc})
         2'b10:   outstanding_in = outstanding_ff + 3'd1;
         2'b01:   outstanding_in = outstanding_ff - 3'd1;
         default: outstanding_in = outstanding_ff;
      endcase
      prev_valid_in = prev_valid_ff || rsp_acc;
      prev_phase_in = rsp_acc ? rsp_capture_phase : prev_phase_ff;
      prev_mark_in  = rsp_acc ? rsp_leader_mark_ticks : prev_mark_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 3'd0;
         prev_valid_ff  <= 1'b0;
         prev_phase_ff  <= PH_WAITING;
         prev_mark_ff   <= 16'd0;
      end else begin
         outstanding_ff <= outstanding_in;
         prev_valid_ff  <= prev_valid_in;
         prev_phase_ff  <= prev_phase_in;
         prev_mark_ff   <= prev_mark_in;
      end
   end

   `IRPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_capture_phase) && $stable(rsp_leader_mark_ticks) && $stable(rsp_leader_space_ticks) && $stable(rsp_stored_count) && $stable(rsp_read_width) && $stable(rsp_next_edge_rising), "response changed while stalled")
   `IRPC_ASSERT_NOW(a_no_spurious_rsp, rsp_acc, outstanding_ff != 3'd0, "response without a pending event")
   `IRPC_ASSERT_NOW(a_mark_frozen, rsp_acc && prev_valid_ff && (rsp_capture_phase == prev_phase_ff) && (rsp_capture_phase != PH_WAITING) && (rsp_capture_phase != PH_MARK), rsp_leader_mark_ticks == prev_mark_ff, "leader mark changed outside leader mark")
   `IRPC_ASSERT_NOW(a_idle_polarity, rsp_valid && ((rsp_capture_phase == PH_WAITING) || (rsp_capture_phase == PH_PENDING)), !rsp_next_edge_rising, "rising edge expected while idle")

endmodule

bind ir_pulse_capture irpc_checker u_irpc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_bus.valid),
   .req_ready              (req_bus.ready),
   .rsp_valid              (rsp_bus.valid),
   .rsp_ready              (rsp_bus.ready),
   .rsp_capture_phase      (rsp_bus.capture_phase),
   .rsp_leader_mark_ticks  (rsp_bus.leader_mark_ticks),
   .rsp_leader_space_ticks (rsp_bus.leader_space_ticks),
   .rsp_stored_count       (rsp_bus.stored_count),
   .rsp_read_width         (rsp_bus.read_width),
   .rsp_next_edge_rising   (rsp_bus.next_edge_rising)
);
